// ===== design/glzw_pkg.sv =====
// Shared types and constants for the GIF LZW pixel decoder.
// Used by glzw_ctrl, glzw_dp and gif_lzw_pixel_decoder; depends on nothing.
package glzw_pkg;

	localparam int TABLE_ENTRIES_DEF   = 4096;
	localparam int MAX_WIDTH_DEF       = 4096;
	localparam int MAX_HEIGHT_DEF      = 4096;
	localparam int PALETTE_ENTRIES_DEF = 256;

	localparam logic [3:0] MAX_ROOT_SIZE = 4'd11;
	localparam logic [3:0] MAX_CODE_BITS = 4'd12;

	typedef enum logic [1:0] {
		MODE_PALETTE = 2'd0,
		MODE_START   = 2'd1,
		MODE_BYTE    = 2'd2,
		MODE_PIXEL   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_PIXEL   = 3'd0,
		ST_NEED    = 3'd1,
		ST_OK      = 3'd2,
		ST_END     = 3'd3,
		ST_REJECT  = 3'd4,
		ST_BADSIZE = 3'd5
	} status_t;

	localparam logic [1:0] REG_WIDTH     = 2'd0;
	localparam logic [1:0] REG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_INTERLACE = 2'd2;

	// Commands from the controller to the datapath, one cycle each.
	typedef struct packed {
		logic    load_item;
		logic    pal_write;
		logic    start;
		logic    set_end;
		logic    block_len;
		logic    shift_in;
		logic    take_code;
		logic    do_clear;
		logic    first_code;
		logic    begin_walk;
		logic    walk_step;
		logic    finish;
		logic    pop;
		logic    pix_prep;
		logic    pix_adv;
		logic    out_load;
		status_t out_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t mode;
		logic  ended;
		logic  dims_ok;
		logic  size_bad;
		logic  blk_zero;
		logic  buf_full;
		logic  stack_empty;
		logic  have_bits;
		logic  is_clear;
		logic  is_end;
		logic  prev_valid;
		logic  code_ge_clear;
		logic  code_ok;
		logic  walk_more;
	} sts_t;

	function automatic logic [3:0] pass_step(input logic [1:0] p);
		case (p)
			2'd0:    pass_step = 4'd8;
			2'd1:    pass_step = 4'd8;
			2'd2:    pass_step = 4'd4;
			default: pass_step = 4'd2;
		endcase
	endfunction

	function automatic logic [3:0] pass_first(input logic [1:0] p);
		case (p)
			2'd0:    pass_first = 4'd0;
			2'd1:    pass_first = 4'd4;
			2'd2:    pass_first = 4'd2;
			default: pass_first = 4'd1;
		endcase
	endfunction

endpackage

// ===== design/glzw_ctrl.sv =====
// Sequencing state machine of the GIF LZW pixel decoder.
// Depends on glzw_pkg; drives glzw_dp through cmd_t and reads sts_t.
module glzw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  glzw_pkg::sts_t sts,
	output glzw_pkg::cmd_t cmd
);
	import glzw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_FETCH, S_DECODE, S_WALK_ISSUE, S_WALK_DATA,
		S_FINISH, S_POP, S_PAL, S_PIX, S_OUT
	} state_t;

	state_t  state_q, state_n;
	status_t res_q, res_n;
	logic    out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.out_status = res_q;
		state_n = state_q;
		res_n   = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_n = S_OUT;
				res_n   = ST_OK;
				case (sts.mode)
					MODE_PALETTE: cmd.pal_write = 1'b1;
					MODE_START: begin
						if (sts.size_bad) begin
							cmd.set_end = 1'b1;
							res_n = ST_BADSIZE;
						end else begin
							cmd.start = 1'b1;
						end
					end
					MODE_BYTE: begin
						if (sts.ended) begin
							res_n = ST_REJECT;
						end else if (sts.blk_zero) begin
							cmd.block_len = 1'b1;
						end else if (sts.buf_full) begin
							res_n = ST_REJECT;
						end else begin
							cmd.shift_in = 1'b1;
						end
					end
					default: begin
						if (sts.ended || !sts.dims_ok) begin
							cmd.set_end = 1'b1;
							res_n = ST_END;
						end else if (!sts.stack_empty) begin
							state_n = S_POP;
						end else begin
							state_n = S_FETCH;
						end
					end
				endcase
			end
			S_FETCH: begin
				if (!sts.have_bits) begin
					res_n   = ST_NEED;
					state_n = S_OUT;
				end else begin
					cmd.take_code = 1'b1;
					state_n = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_clear) begin
					cmd.do_clear = 1'b1;
					state_n = S_FETCH;
				end else if (sts.is_end || (!sts.prev_valid && sts.code_ge_clear) ||
					(sts.prev_valid && !sts.code_ok)) begin
					cmd.set_end = 1'b1;
					res_n   = ST_END;
					state_n = S_OUT;
				end else if (!sts.prev_valid) begin
					cmd.first_code = 1'b1;
					state_n = S_POP;
				end else begin
					cmd.begin_walk = 1'b1;
					state_n = S_WALK_ISSUE;
				end
			end
			S_WALK_ISSUE: begin
				state_n = sts.walk_more ? S_WALK_DATA : S_FINISH;
			end
			S_WALK_DATA: begin
				cmd.walk_step = 1'b1;
				state_n = S_WALK_ISSUE;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_n = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_n = S_PAL;
			end
			S_PAL: begin
				cmd.pix_prep = 1'b1;
				state_n = S_PIX;
			end
			S_PIX: begin
				cmd.pix_adv = 1'b1;
				res_n   = ST_PIXEL;
				state_n = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			res_q   <= res_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/glzw_dp.sv =====
// Datapath of the GIF LZW pixel decoder: bit buffer, code table, expansion
// stack, palette and raster position. Depends on glzw_pkg; run by glzw_ctrl.
module glzw_dp #(
	parameter int TABLE_ENTRIES   = glzw_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_WIDTH       = glzw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = glzw_pkg::MAX_HEIGHT_DEF,
	parameter int PALETTE_ENTRIES = glzw_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     in_mode,
	input  logic [7:0]     in_palette_index,
	input  logic [23:0]    in_palette_color,
	input  logic [3:0]     in_min_code_size,
	input  logic [7:0]     in_stream_byte,
	input  logic [12:0]    image_width,
	input  logic [12:0]    image_height,
	input  logic           interlace_enable,
	input  glzw_pkg::cmd_t cmd,
	output glzw_pkg::sts_t sts,
	output logic [2:0]     status,
	output logic [23:0]    pixel_color,
	output logic [23:0]    pixel_address,
	output logic           last_pixel
);
	import glzw_pkg::*;

	localparam int TAB_AW = $clog2(TABLE_ENTRIES);
	localparam int SP_W   = TAB_AW + 1;
	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam logic [12:0]   TAB_END = 13'(TABLE_ENTRIES);
	localparam logic [SP_W-1:0] SP_END = SP_W'(TABLE_ENTRIES);

	// Latched input word
	mode_t       mode_q;
	logic [7:0]  pidx_q, byte_q;
	logic [23:0] pcol_q;
	logic [3:0]  mcs_q;

	// Decoder state
	logic [23:0]     bitbuf_q;
	logic [4:0]      bitcnt_q;
	logic [7:0]      blk_q;
	logic [3:0]      cw_q, root_q;
	logic [12:0]     nf_q;
	logic [11:0]     prev_q, code_q, c_q, incode_q;
	logic            prev_v_q, ended_q;
	logic [7:0]      fs_q;
	logic [SP_W-1:0] sp_q;
	logic [12:0]     col_q, row_q, rows_q;
	logic [1:0]      pass_q;

	// Pixel staging and output word
	logic [23:0] addr_q, res_color_q, res_addr_q, out_color_q, out_addr_q;
	logic        res_last_q, out_last_q, sym_ok_q;
	status_t     out_status_q;

	// Memories
	logic [11:0] prefix_mem [TABLE_ENTRIES];
	logic [7:0]  suffix_mem [TABLE_ENTRIES];
	logic [7:0]  stack_mem  [TABLE_ENTRIES];
	logic [23:0] pal_mem    [PALETTE_ENTRIES];
	logic [11:0] prefix_rd;
	logic [7:0]  suffix_rd, stk_rd;
	logic [23:0] pal_rd;

	logic [12:0] clear_c, first_c, code_w, mask13, nf_inc, cw_lim;
	logic [11:0] code_x;
	logic [16:0] w17, h17, size17;
	logic        is_kwk, push_en, tab_we;
	logic [7:0]  push_data;
	logic [SP_W-1:0] sp_m1;

	assign clear_c = 13'(1) << root_q;
	assign first_c = clear_c + 13'd2;
	assign code_w  = {1'b0, code_q};
	assign mask13  = (13'(1) << cw_q) - 13'd1;
	assign code_x  = bitbuf_q[11:0] & mask13[11:0];
	assign w17     = {4'd0, image_width};
	assign h17     = {4'd0, image_height};
	assign size17  = (17'(1) << mcs_q) + 17'd2;
	assign is_kwk  = (code_w == nf_q);
	assign nf_inc  = nf_q + 13'd1;
	assign cw_lim  = 13'(1) << cw_q;
	assign sp_m1   = sp_q - SP_W'(1);

	always_comb begin
		sts.mode          = mode_q;
		sts.ended         = ended_q;
		sts.dims_ok       = (w17 >= 17'd1) && (w17 <= 17'(MAX_WIDTH)) &&
			(h17 >= 17'd1) && (h17 <= 17'(MAX_HEIGHT));
		sts.size_bad      = (mcs_q > MAX_ROOT_SIZE) || (size17 > 17'(TABLE_ENTRIES));
		sts.blk_zero      = (blk_q == 8'd0);
		sts.buf_full      = (bitcnt_q > 5'd16);
		sts.stack_empty   = (sp_q == '0);
		sts.have_bits     = (bitcnt_q >= {1'b0, cw_q});
		sts.is_clear      = (code_w == clear_c);
		sts.is_end        = (code_w == clear_c + 13'd1);
		sts.prev_valid    = prev_v_q;
		sts.code_ge_clear = (code_w >= clear_c);
		sts.code_ok       = (code_w < nf_q) || (is_kwk && nf_q < TAB_END);
		sts.walk_more     = ({1'b0, c_q} >= first_c);
	end

	// One symbol goes onto the stack per cycle at most.
	always_comb begin
		push_en   = 1'b0;
		push_data = fs_q;
		if (cmd.first_code) begin
			push_en   = 1'b1;
			push_data = code_q[7:0];
		end else if (cmd.begin_walk && is_kwk) begin
			push_en   = 1'b1;
			push_data = fs_q;
		end else if (cmd.walk_step) begin
			push_en   = 1'b1;
			push_data = suffix_rd;
		end else if (cmd.finish) begin
			push_en   = 1'b1;
			push_data = c_q[7:0];
		end
	end

	assign tab_we = cmd.finish && (nf_q < TAB_END);

	always_ff @(posedge clk) begin
		if (tab_we) begin
			prefix_mem[nf_q[TAB_AW-1:0]] <= prev_q;
			suffix_mem[nf_q[TAB_AW-1:0]] <= c_q[7:0];
		end
		prefix_rd <= prefix_mem[c_q[TAB_AW-1:0]];
		suffix_rd <= suffix_mem[c_q[TAB_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (push_en && sp_q < SP_END)
			stack_mem[sp_q[TAB_AW-1:0]] <= push_data;
		stk_rd <= stack_mem[sp_m1[TAB_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.pal_write && ({1'b0, pidx_q} < 9'(PALETTE_ENTRIES)))
			pal_mem[pidx_q[PAL_AW-1:0]] <= pcol_q;
		pal_rd <= pal_mem[stk_rd[PAL_AW-1:0]];
	end

	// Item latch, code and walk registers, symbol check and pixel address carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= mode_t'(in_mode);
			pidx_q <= in_palette_index;
			pcol_q <= in_palette_color;
			mcs_q  <= in_min_code_size;
			byte_q <= in_stream_byte;
		end
		if (cmd.take_code)
			code_q <= code_x;
		if (cmd.begin_walk) begin
			incode_q <= code_q;
			c_q      <= is_kwk ? prev_q : code_q;
		end else if (cmd.walk_step) begin
			c_q <= prefix_rd;
		end
		if (cmd.pix_prep) begin
			sym_ok_q <= ({1'b0, stk_rd} < 9'(PALETTE_ENTRIES));
			addr_q   <= 24'(26'(row_q) * 26'(image_width) + 26'(col_q));
		end
	end

	logic [12:0] col_n, rows_n;
	logic [13:0] row_n;
	logic [1:0]  pass_n;
	logic        last_n, wrap;

	// Raster advance; passes whose first row is beyond the height are skipped.
	always_comb begin
		col_n  = col_q + 13'd1;
		rows_n = rows_q;
		row_n  = {1'b0, row_q};
		pass_n = pass_q;
		last_n = 1'b0;
		wrap   = (col_n >= image_width);
		if (wrap) begin
			col_n  = 13'd0;
			rows_n = rows_q + 13'd1;
			if (rows_n >= image_height) begin
				last_n = 1'b1;
			end else if (interlace_enable) begin
				row_n = {1'b0, row_q} + 14'(pass_step(pass_q));
				for (int k = 0; k < 3; k++) begin
					if (row_n >= {1'b0, image_height} && pass_n < 2'd3) begin
						pass_n = pass_n + 2'd1;
						row_n  = 14'(pass_first(pass_n));
					end
				end
			end else begin
				row_n = {1'b0, row_q} + 14'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitbuf_q     <= '0;
			bitcnt_q     <= '0;
			blk_q        <= '0;
			cw_q         <= '0;
			root_q       <= '0;
			nf_q         <= '0;
			prev_q       <= '0;
			prev_v_q     <= 1'b0;
			fs_q         <= '0;
			sp_q         <= '0;
			col_q        <= '0;
			row_q        <= '0;
			rows_q       <= '0;
			pass_q       <= '0;
			ended_q      <= 1'b1;
			res_color_q  <= '0;
			res_addr_q   <= '0;
			res_last_q   <= 1'b0;
			out_color_q  <= '0;
			out_addr_q   <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= ST_OK;
		end else begin
			if (cmd.set_end)
				ended_q <= 1'b1;
			if (cmd.start) begin
				root_q   <= mcs_q;
				bitbuf_q <= '0;
				bitcnt_q <= '0;
				blk_q    <= '0;
				cw_q     <= mcs_q + 4'd1;
				nf_q     <= size17[12:0];
				prev_q   <= '0;
				prev_v_q <= 1'b0;
				fs_q     <= '0;
				sp_q     <= '0;
				col_q    <= '0;
				row_q    <= '0;
				rows_q   <= '0;
				pass_q   <= '0;
				ended_q  <= !sts.dims_ok;
			end
			if (cmd.block_len) begin
				if (byte_q == 8'd0)
					ended_q <= 1'b1;
				else
					blk_q <= byte_q;
			end
			if (cmd.shift_in) begin
				bitbuf_q <= bitbuf_q | (24'(byte_q) << bitcnt_q);
				bitcnt_q <= bitcnt_q + 5'd8;
				blk_q    <= blk_q - 8'd1;
			end
			if (cmd.take_code) begin
				bitbuf_q <= bitbuf_q >> cw_q;
				bitcnt_q <= bitcnt_q - {1'b0, cw_q};
			end
			if (cmd.do_clear) begin
				cw_q     <= root_q + 4'd1;
				nf_q     <= first_c;
				prev_v_q <= 1'b0;
			end
			if (cmd.first_code) begin
				prev_q   <= code_q;
				prev_v_q <= 1'b1;
				fs_q     <= code_q[7:0];
			end
			if (cmd.finish) begin
				fs_q   <= c_q[7:0];
				prev_q <= incode_q;
				if (tab_we) begin
					nf_q <= nf_inc;
					if (nf_inc >= cw_lim && nf_inc < TAB_END && cw_q < MAX_CODE_BITS)
						cw_q <= cw_q + 4'd1;
				end
			end
			if (push_en && sp_q < SP_END)
				sp_q <= sp_q + SP_W'(1);
			else if (cmd.pop)
				sp_q <= sp_m1;
			if (cmd.pix_adv) begin
				res_color_q <= sym_ok_q ? pal_rd : 24'd0;
				res_addr_q  <= addr_q;
				res_last_q  <= last_n;
				col_q       <= col_n;
				rows_q      <= rows_n;
				row_q       <= row_n[12:0];
				pass_q      <= pass_n;
				if (last_n)
					ended_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_status_q <= cmd.out_status;
				if (cmd.out_status == ST_PIXEL) begin
					out_color_q <= res_color_q;
					out_addr_q  <= res_addr_q;
					out_last_q  <= res_last_q;
				end else begin
					out_color_q <= '0;
					out_addr_q  <= '0;
					out_last_q  <= 1'b0;
				end
			end
		end
	end

	assign status        = out_status_q;
	assign pixel_color   = out_color_q;
	assign pixel_address = out_addr_q;
	assign last_pixel    = out_last_q;

endmodule

// ===== design/gif_lzw_pixel_decoder.sv =====
// GIF LZW pixel decoder: one result word for every input word, one word in work at a time.
// Palette, start and byte words pass dispatch to the output register; a pixel request from a
// filled stack passes dispatch, pop, palette and pixel states, a need-byte answer dispatch
// and fetch. A code read adds fetch and decode; a table walk adds a finish state and, per
// prefix step, issue and data states for the registered table read. A held result stalls
// only the next load. Async active-low reset leaves the decoder ended, with no clearing pass.
module gif_lzw_pixel_decoder #(
	parameter int TABLE_ENTRIES   = glzw_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_WIDTH       = glzw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = glzw_pkg::MAX_HEIGHT_DEF,
	parameter int PALETTE_ENTRIES = glzw_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// palette_index[7:0], palette_color[31:8], min_code_size[35:32],
	// stream_byte[43:36], zero fill above
	input  logic [47:0] s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_color[23:0], pixel_address[47:24]
	output logic [47:0] m_axis_tdata,
	// status[2:0]
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import glzw_pkg::*;

	logic [12:0] width_q, height_q;
	logic        interlace_q;
	cmd_t        cmd;
	sts_t        sts;
	logic [23:0] color, address;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 13'd1;
			height_q    <= 13'd1;
			interlace_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_WIDTH:     width_q     <= pwdata[12:0];
				REG_HEIGHT:    height_q    <= pwdata[12:0];
				REG_INTERLACE: interlace_q <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:     prdata = {19'd0, width_q};
			REG_HEIGHT:    prdata = {19'd0, height_q};
			REG_INTERLACE: prdata = {31'd0, interlace_q};
			default:       prdata = '0;
		endcase
	end

	glzw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	glzw_dp #(
		.TABLE_ENTRIES   (TABLE_ENTRIES),
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_mode          (s_axis_tuser),
		.in_palette_index (s_axis_tdata[7:0]),
		.in_palette_color (s_axis_tdata[31:8]),
		.in_min_code_size (s_axis_tdata[35:32]),
		.in_stream_byte   (s_axis_tdata[43:36]),
		.image_width      (width_q),
		.image_height     (height_q),
		.interlace_enable (interlace_q),
		.cmd              (cmd),
		.sts              (sts),
		.status           (m_axis_tuser),
		.pixel_color      (color),
		.pixel_address    (address),
		.last_pixel       (m_axis_tlast)
	);

	assign m_axis_tdata = {address, color};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for gif_lzw_pixel_decoder: builds LZW code streams,
// feeds palette, start, byte and pixel-request words and checks every result word.
// Depends on glzw_pkg and the decoder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import glzw_pkg::*;

	localparam int ITEM_GOAL = 1850;
	localparam int IDLE_LIMIT = 40000;
	localparam int NCODES = 4096;

	typedef struct {
		status_t     st;
		logic [23:0] color;
		logic [23:0] addr;
		logic        last;
	} pix_word_t;

	typedef struct {
		mode_t       mode;
		logic [7:0]  idx;
		logic [23:0] color;
		logic [3:0]  mcs;
		logic [7:0]  byt;
		bit          typed;
		status_t     st;
		logic [23:0] pcolor;
		logic [23:0] paddr;
		bit          plast;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gif_lzw_pixel_decoder DUT (.*);

	// Decoder image: configuration and state as the block should hold them.
	int unsigned img_w = 1, img_h = 1, img_ilace = 0;
	logic [11:0] prefix_q[NCODES];
	logic [7:0]  suffix_q[NCODES];
	logic [7:0]  stack_q[NCODES];
	logic [23:0] palette_q[256];
	int unsigned bits_q, nbits, blk_left, code_w, free_code, prev_code, first_sym;
	int unsigned depth, col, row, rows_done, ipass, root_sz;
	bit          prev_ok;
	bit          dec_ended = 1'b1;
	const int unsigned row_step[4] = '{8, 8, 4, 2};
	const int unsigned row_first[4] = '{0, 4, 2, 1};

	pix_word_t   pixels_due[$];
	int          items;
	int          errors;
	int          idle_cycles;
	bit          calm;
	int          rx_hold;

	function automatic bit dims_fine();
		return img_w >= 1 && img_w <= 4096 && img_h >= 1 && img_h <= 4096;
	endfunction

	function automatic void push_sym(int unsigned s);
		if (depth < NCODES) begin
			stack_q[depth] = s[7:0];
			depth++;
		end
	endfunction

	// Pulls codes until the stack holds a symbol, the bits run out or data ends.
	function automatic status_t fill_stack();
		int unsigned clr, fe, code, in_code, c;
		clr = 1 << root_sz;
		fe = clr + 2;
		while (depth == 0) begin
			if (nbits < code_w)
				return ST_NEED;
			code = bits_q & ((1 << code_w) - 1);
			bits_q >>= code_w;
			nbits -= code_w;
			if (code == clr) begin
				code_w = root_sz + 1;
				free_code = fe;
				prev_ok = 1'b0;
				continue;
			end
			if (code == clr + 1)
				return ST_END;
			if (!prev_ok) begin
				if (code >= clr)
					return ST_END;
				push_sym(32'(suffix_q[code]));
				prev_code = code;
				prev_ok = 1'b1;
				first_sym = code & 8'hFF;
				continue;
			end
			if (!(code < free_code || (code == free_code && free_code < NCODES)))
				return ST_END;
			in_code = code;
			c = code;
			if (code == free_code) begin
				push_sym(first_sym);
				c = prev_code;
			end
			while (c >= fe && c < NCODES && depth < NCODES) begin
				push_sym(32'(suffix_q[c]));
				c = 32'(prefix_q[c]);
			end
			first_sym = (c < NCODES) ? 32'(suffix_q[c]) : 0;
			push_sym(first_sym);
			if (free_code < NCODES) begin
				prefix_q[free_code] = prev_code[11:0];
				suffix_q[free_code] = first_sym[7:0];
				free_code++;
				if (free_code >= (1 << code_w) && free_code < NCODES && code_w < 12)
					code_w++;
			end
			prev_code = in_code;
		end
		return ST_PIXEL;
	endfunction

	function automatic pix_word_t decode_word(mode_t m, logic [7:0] idx, logic [23:0] colr,
			logic [3:0] mcs, logic [7:0] byt);
		pix_word_t r;
		int unsigned sym;
		r = '{ST_OK, 24'd0, 24'd0, 1'b0};
		case (m)
			MODE_PALETTE: palette_q[idx] = colr;
			MODE_START: begin
				if (mcs > MAX_ROOT_SIZE) begin
					dec_ended = 1'b1;
					r.st = ST_BADSIZE;
				end else begin
					root_sz = 32'(mcs);
					for (int k = 0; k < (1 << mcs); k++) begin
						prefix_q[k] = '0;
						suffix_q[k] = k[7:0];
					end
					bits_q = 0;
					nbits = 0;
					blk_left = 0;
					code_w = 32'(mcs) + 1;
					free_code = (1 << mcs) + 2;
					prev_code = 0;
					prev_ok = 1'b0;
					first_sym = 0;
					depth = 0;
					col = 0;
					row = 0;
					rows_done = 0;
					ipass = 0;
					dec_ended = !dims_fine();
				end
			end
			MODE_BYTE: begin
				if (dec_ended)
					r.st = ST_REJECT;
				else if (blk_left == 0) begin
					if (byt == 0)
						dec_ended = 1'b1;
					else
						blk_left = 32'(byt);
				end else if (nbits > 16)
					r.st = ST_REJECT;
				else begin
					bits_q = (bits_q | (int'(byt) << nbits)) & 24'hFFFFFF;
					nbits += 8;
					blk_left--;
				end
			end
			default: begin
				if (dec_ended || !dims_fine()) begin
					dec_ended = 1'b1;
					r.st = ST_END;
				end else begin
					r.st = fill_stack();
					if (r.st == ST_END)
						dec_ended = 1'b1;
					else if (r.st == ST_PIXEL) begin
						depth--;
						sym = 32'(stack_q[depth]);
						r.color = palette_q[sym];
						r.addr = 24'(row * img_w + col);
						col++;
						if (col >= img_w) begin
							col = 0;
							rows_done++;
							if (rows_done >= img_h) begin
								dec_ended = 1'b1;
								r.last = 1'b1;
							end else if (img_ilace != 0) begin
								row += row_step[ipass];
								while (row >= img_h && ipass < 3) begin
									ipass++;
									row = row_first[ipass];
								end
							end else
								row++;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = 1'b1;
			#6 clk = 1'b0;
		end
	end

	// Result side: random back-pressure bursts, none near the end of the run.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 7) == 0)
				rx_hold = $urandom_range(1, 6);
		end
	end

	always @(posedge clk) begin
		pix_word_t e;
		idle_cycles++;
		if (s_axis_tvalid && s_axis_tready)
			idle_cycles = 0;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			idle_cycles = 0;
			if (pixels_due.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected, status %0d", $time,
					m_axis_tuser);
			end else begin
				e = pixels_due.pop_front();
				if (m_axis_tuser != e.st) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, e.st, m_axis_tuser);
				end
				if (m_axis_tdata[23:0] != e.color) begin
					errors++;
					$display("%0t: pixel_color expected %h actual %h", $time, e.color,
						m_axis_tdata[23:0]);
				end
				if (m_axis_tdata[47:24] != e.addr) begin
					errors++;
					$display("%0t: pixel_address expected %0d actual %0d", $time, e.addr,
						m_axis_tdata[47:24]);
				end
				if (m_axis_tlast != e.last) begin
					errors++;
					$display("%0t: last_pixel expected %0d actual %0d", $time, e.last,
						m_axis_tlast);
				end
			end
		end
		if (idle_cycles > IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_word(input mode_t m, input logic [7:0] idx, input logic [23:0] colr,
			input logic [3:0] mcs, input logic [7:0] byt, input bit typed,
			input pix_word_t want, output pix_word_t got);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= m;
		s_axis_tdata <= {4'd0, byt, mcs, colr, idx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		got = decode_word(m, idx, colr, mcs, byt);
		pixels_due.push_back(typed ? want : got);
		items++;
	endtask

	task automatic wait_quiet();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned v);
		wait_quiet();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk) penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH:  img_w = v & 13'h1FFF;
			REG_HEIGHT: img_h = v & 13'h1FFF;
			default:    img_ilace = v & 1;
		endcase
	endtask

	// Builds a sub-blocked code stream. kind 0: normal with end code,
	// kind 1: no end code (terminator ends it), kind 2: a non-root first code.
	// The first code after a clear adds no table entry.
	task automatic build_stream(input int mcs, input int ncodes, input int kind,
			ref logic [7:0] q[$]);
		logic [7:0]  raw[$];
		longint unsigned acc;
		int unsigned clr, w, nf, code, hi, na, n, i;
		bit          pv, fresh;
		clr = 1 << mcs;
		w = mcs + 1;
		nf = clr + 2;
		pv = 1'b0;
		acc = 0;
		na = 0;
		q.delete();
		for (int k = -1; k <= ncodes; k++) begin
			fresh = 1'b0;
			if (k == -1)
				code = clr;
			else if (k == ncodes)
				code = (kind == 1) ? clr : clr + 1;
			else if (kind == 2 && k == ncodes / 2) begin
				code = clr;
				pv = 1'b0;
			end else if (kind == 2 && k == ncodes / 2 + 1)
				code = (mcs >= 2) ? clr + 2 : clr + 1;
			else if (pv && $urandom_range(0, 39) == 0) begin
				code = clr;
				pv = 1'b0;
			end else if (!pv) begin
				code = $urandom_range(0, clr - 1);
				pv = 1'b1;
				fresh = 1'b1;
			end else begin
				hi = (nf < (1 << w) - 1) ? nf : (1 << w) - 1;
				if (hi >= clr + 2 && $urandom_range(0, 1))
					code = $urandom_range(clr + 2, hi);
				else begin
					do
						code = $urandom_range(0, hi);
					while (code == clr || code == clr + 1);
				end
			end
			acc |= longint'(code) << na;
			na += w;
			while (na >= 8) begin
				raw.push_back(acc[7:0]);
				acc >>= 8;
				na -= 8;
			end
			if (code == clr) begin
				w = mcs + 1;
				nf = clr + 2;
			end else if (k >= 0 && k < ncodes && pv && !fresh && code != clr + 1 &&
					nf < NCODES) begin
				nf++;
				if (nf >= (1 << w) && nf < NCODES && w < 12)
					w++;
			end
			if (kind == 2 && k == ncodes / 2 + 1)
				break;
		end
		if (na > 0)
			raw.push_back(acc[7:0]);
		i = 0;
		while (i < raw.size()) begin
			n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 255 : 12);
			if (n > raw.size() - i)
				n = raw.size() - i;
			q.push_back(n[7:0]);
			repeat (n) begin
				q.push_back(raw[i]);
				i++;
			end
		end
		q.push_back(8'd0);
	endtask

	task automatic run_image(input int mcs, input int kind);
		logic [7:0] strm[$];
		pix_word_t  r, none;
		int         bi, npix;
		bit         want;
		none = '{ST_OK, 24'd0, 24'd0, 1'b0};
		build_stream(mcs, ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
			: $urandom_range(3, 40), kind, strm);
		send_word(MODE_START, 8'($urandom), 24'($urandom), 4'(mcs), 8'($urandom), 1'b0,
			none, r);
		if (dec_ended) begin
			send_word(MODE_PIXEL, 8'($urandom), 24'($urandom), 4'($urandom), 8'($urandom),
				1'b0, none, r);
			send_word(MODE_BYTE, 8'($urandom), 24'($urandom), 4'($urandom), 8'($urandom),
				1'b0, none, r);
			return;
		end
		bi = 0;
		npix = 0;
		want = 1'b0;
		forever begin
			if (dec_ended) begin
				if (bi < strm.size() && $urandom_range(0, 1))
					send_word(MODE_BYTE, 8'($urandom), 24'($urandom), 4'($urandom), strm[bi],
						1'b0, none, r);
				break;
			end
			if (bi < strm.size() && (want || $urandom_range(0, 3) == 0) &&
					!(blk_left != 0 && nbits > 16 && $urandom_range(0, 3) != 0)) begin
				send_word(MODE_BYTE, 8'($urandom), 24'($urandom), 4'($urandom), strm[bi],
					1'b0, none, r);
				if (r.st != ST_REJECT)
					bi++;
				want = 1'b0;
			end else begin
				if (kind == 3 && npix == 2)
					write_reg(REG_WIDTH, 0);
				send_word(MODE_PIXEL, 8'($urandom), 24'($urandom), 4'($urandom), 8'($urandom),
					1'b0, none, r);
				npix++;
				if (r.st == ST_NEED) begin
					want = 1'b1;
					if (bi >= strm.size())
						break;
				end
			end
		end
	endtask

	row_t directed[19] = '{
		'{MODE_PIXEL,   8'h00, 24'h000000, 4'd0,  8'h00, 1, ST_END,    0, 0, 0},
		'{MODE_BYTE,    8'h00, 24'h000000, 4'd0,  8'hA5, 1, ST_REJECT, 0, 0, 0},
		'{MODE_PALETTE, 8'h00, 24'h000000, 4'd0,  8'h00, 1, ST_OK,     0, 0, 0},
		'{MODE_PALETTE, 8'hFF, 24'hFFFFFF, 4'hF,  8'hFF, 1, ST_OK,     0, 0, 0},
		'{MODE_PALETTE, 8'h01, 24'h123456, 4'd0,  8'h00, 1, ST_OK,     0, 0, 0},
		'{MODE_START,   8'h00, 24'h000000, 4'd15, 8'h00, 1, ST_BADSIZE, 0, 0, 0},
		'{MODE_START,   8'h00, 24'h000000, 4'd12, 8'h00, 1, ST_BADSIZE, 0, 0, 0},
		'{MODE_BYTE,    8'h00, 24'h000000, 4'd0,  8'h02, 1, ST_REJECT, 0, 0, 0},
		'{MODE_START,   8'h00, 24'h000000, 4'd2,  8'h00, 1, ST_OK,     0, 0, 0},
		'{MODE_PIXEL,   8'h00, 24'h000000, 4'd0,  8'h00, 1, ST_NEED,   0, 0, 0},
		// Clear, root 0, end code at three bits each.
		'{MODE_BYTE,    8'h00, 24'h000000, 4'd0,  8'h02, 1, ST_OK,     0, 0, 0},
		'{MODE_BYTE,    8'h00, 24'h000000, 4'd0,  8'h44, 1, ST_OK,     0, 0, 0},
		'{MODE_BYTE,    8'h00, 24'h000000, 4'd0,  8'h01, 1, ST_OK,     0, 0, 0},
		'{MODE_PIXEL,   8'h00, 24'h000000, 4'd0,  8'h00, 1, ST_PIXEL,  0, 0, 1},
		'{MODE_PIXEL,   8'h00, 24'h000000, 4'd0,  8'h00, 1, ST_END,    0, 0, 0},
		'{MODE_START,   8'h00, 24'h000000, 4'd3,  8'h00, 1, ST_OK,     0, 0, 0},
		// A zero-length sub-block ends the image at once.
		'{MODE_BYTE,    8'h00, 24'h000000, 4'd0,  8'h00, 1, ST_OK,     0, 0, 0},
		'{MODE_PIXEL,   8'h00, 24'h000000, 4'd0,  8'h00, 0, ST_END,    0, 0, 0},
		'{MODE_BYTE,    8'h00, 24'h000000, 4'd0,  8'h07, 1, ST_REJECT, 0, 0, 0}
	};

	initial begin
		pix_word_t r, want;
		int        sel, mcs, kind;
		for (int k = 0; k < NCODES; k++) begin
			prefix_q[k] = '0;
			suffix_q[k] = '0;
			stack_q[k] = '0;
		end
		for (int k = 0; k < 256; k++)
			palette_q[k] = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_PALETTE;
		m_axis_tready = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (directed[i]) begin
			want = '{directed[i].st, directed[i].pcolor, directed[i].paddr, directed[i].plast};
			send_word(directed[i].mode, directed[i].idx, directed[i].color, directed[i].mcs,
				directed[i].byt, directed[i].typed, want, r);
		end

		// Every palette entry is written before any random image reads one.
		for (int k = 0; k < 256; k++)
			send_word(MODE_PALETTE, 8'(k), 24'($urandom), 4'($urandom), 8'($urandom), 1'b0,
				want, r);

		write_reg(REG_INTERLACE, 1);
		for (int ph = 0; items < ITEM_GOAL; ph++) begin
			calm = items > ITEM_GOAL * 85 / 100;
			if (ph < 6 || $urandom_range(0, 2) == 0) begin
				case ((ph < 6) ? ph : $urandom_range(6, 14))
					0: begin
						write_reg(REG_WIDTH, 4096);
						write_reg(REG_HEIGHT, 1);
					end
					1: begin
						write_reg(REG_WIDTH, 1);
						write_reg(REG_HEIGHT, 4096);
					end
					2: begin
						write_reg(REG_WIDTH, 0);
						write_reg(REG_HEIGHT, 3);
					end
					3: begin
						write_reg(REG_WIDTH, 8191);
						write_reg(REG_HEIGHT, 8191);
					end
					4: begin
						write_reg(REG_WIDTH, 3);
						write_reg(REG_HEIGHT, 4097);
					end
					default: begin
						write_reg(REG_WIDTH, $urandom_range(1, 16));
						write_reg(REG_HEIGHT, $urandom_range(1, 24));
						write_reg(REG_INTERLACE, $urandom_range(0, 1));
					end
				endcase
			end
			sel = $urandom_range(0, 19);
			if (sel == 0)
				mcs = $urandom_range(12, 15);
			else if (sel < 3)
				mcs = $urandom_range(0, 1);
			else if (sel < 5)
				mcs = 11;
			else
				mcs = $urandom_range(2, 8);
			sel = $urandom_range(0, 19);
			kind = (sel < 2) ? 1 : (sel < 4) ? 2 : (sel == 4) ? 3 : 0;
			run_image(mcs, kind);
			if (kind == 3)
				write_reg(REG_WIDTH, $urandom_range(1, 16));
			if ($urandom_range(0, 5) == 0)
				send_word(mode_t'($urandom_range(0, 3)), 8'($urandom), 24'($urandom),
					4'($urandom), 8'($urandom), 1'b0, want, r);
		end

		calm = 1'b1;
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== gif_lzw_pixel_decoder.f =====
design/glzw_pkg.sv
design/glzw_ctrl.sv
design/glzw_dp.sv
design/gif_lzw_pixel_decoder.sv
tb/sv/testbench.sv
